// ===== src/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants for the ramped position controller.
// ----------------------------------------------------------------------------
package pcr_pkg;

	localparam int DIVIDEND_W = 48;
	localparam int DIVISOR_W  = 24;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [31:0]        time_us;
		logic signed [31:0] measured_position;
		logic signed [31:0] new_target;
		logic               load_target;
		logic [30:0]        new_coast_speed;
		logic               load_coast;
		logic               pause_request;
		logic               resume_request;
		logic               stop_request;
	} pcr_in_t;

	typedef struct packed {
		logic signed [31:0] velocity_command;
		logic               at_target;
		logic               is_paused;
		logic signed [31:0] coast_stop_position;
	} pcr_out_t;

	typedef enum logic [2:0] {
		REG_GAIN      = 3'd0,
		REG_COAST_LIM = 3'd1,
		REG_MIN_SPEED = 3'd2,
		REG_ACCEL     = 3'd3,
		REG_WINDOW    = 3'd4,
		REG_SETTLE    = 3'd5,
		REG_REV_WAIT  = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_ERR,
		ST_MUL_DT,
		ST_RAMP,
		ST_APPLY,
		ST_DIV_START,
		ST_DIV,
		ST_FIN
	} pcr_state_t;

endpackage

// ===== src/pcr_div.sv =====
// ----------------------------------------------------------------------------
// pcr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcr_div #(
	parameter int DividendW = pcr_pkg::DIVIDEND_W,
	parameter int DivisorW  = pcr_pkg::DIVISOR_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DividendW-1:0] dividend,
	input  logic [DivisorW-1:0]  divisor,
	output logic                 done,
	output logic [DividendW-1:0] quotient
);
	import pcr_pkg::*;

	localparam int CntW = $clog2(DividendW + 1);

	logic [DivisorW-1:0]  rem_q;
	logic [DividendW-1:0] quo_q;
	logic [CntW-1:0]      cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DivisorW:0]    trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DividendW-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DividendW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend bits out the top, quotient bits in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DivisorW'(trial - {1'b0, divisor}) : trial[DivisorW-1:0];
			quo_q <= {quo_q[DividendW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/position_controller_ramped_unit.sv =====
// ----------------------------------------------------------------------------
// position_controller_ramped_unit
// Proportional position controller with acceleration ramp, reversal dead
// time, settle detection and coast stop position.
// ----------------------------------------------------------------------------
// Each word runs through check, multiply error, multiply dt, ramp and apply
//   when a control step runs; when the tick skips it, check goes straight on.
//   Then the 48-step divider for the coast stop position runs, then finish,
//   which an output stall holds; the multiplier is shared by the two multiply
//   states. No new word is taken before the last is through; in_stall is low
//   only while idle; a finished result waits in the output register. Reset
//   clears all control state and loads register defaults.
module position_controller_ramped_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  pcr_pkg::pcr_in_t  in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output pcr_pkg::pcr_out_t out_word
);
	import pcr_pkg::*;

	pcr_state_t state_q, state_d;

	// configuration
	logic [23:0] gain_q;
	logic [30:0] limit_q;
	logic [30:0] min_q;
	logic [23:0] accel_q;
	logic [30:0] win_q;
	logic [31:0] settle_q;
	logic [31:0] revwait_q;

	// controller state
	logic [31:0]        last_time_q;
	logic signed [31:0] target_q;
	logic [30:0]        coast_q;
	logic signed [31:0] ramp_q;
	logic signed [31:0] outvel_q;
	logic               reached_q;
	logic [31:0]        win_entry_q;
	logic [31:0]        rev_time_q;
	logic               rev_pend_q;
	logic               paused_q;
	logic               stop_q;

	// per-word working registers
	logic [31:0]        now_q;
	logic signed [31:0] meas_q;
	logic [30:0]        dt_q;
	logic               run_q;
	logic signed [57:0] prod_q;
	logic signed [31:0] prop_q;
	logic signed [31:0] next_q;

	logic     out_valid_q;
	pcr_out_t out_q;

	logic accept;
	logic fin_go;
	assign accept = in_valid && !in_stall;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// accept-time command decode
	logic        paused_new;
	logic        resume;
	logic [31:0] dt_full;
	assign paused_new = paused_q | in_word.pause_request;
	assign resume     = in_word.resume_request & paused_new;
	assign dt_full    = in_word.time_us - last_time_q;

	logic rev_hold;
	assign rev_hold = rev_pend_q && ((now_q - rev_time_q) <= revwait_q);

	// shared multiplier
	logic signed [24:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [57:0] mul_p;
	always_comb begin
		if (state_q == ST_MUL_DT) begin
			mul_a = $signed({1'b0, accel_q});
			mul_b = $signed({2'b00, dt_q});
		end else begin
			mul_a = $signed({1'b0, gain_q});
			mul_b = $signed({target_q[31], target_q}) - $signed({meas_q[31], meas_q});
		end
	end
	assign mul_p = mul_a * mul_b;

	// proportional term, truncated toward zero and clamped
	logic signed [57:0] prod_adj;
	logic signed [41:0] prop_full;
	logic [30:0]        cs;
	logic [30:0]        lim;
	logic signed [41:0] lim_s;
	logic signed [31:0] prop_clamp;
	always_comb begin
		prod_adj  = prod_q + (prod_q[57] ? 58'sd65535 : 58'sd0);
		prop_full = 42'(prod_adj >>> 16);
		cs        = (coast_q < limit_q) ? coast_q : limit_q;
		lim       = (cs > min_q) ? cs - min_q : '0;
		lim_s     = $signed({11'b0, lim});
		if (prop_full > lim_s)       prop_clamp = $signed({1'b0, lim});
		else if (prop_full < -lim_s) prop_clamp = -$signed({1'b0, lim});
		else                         prop_clamp = prop_full[31:0];
	end

	// ramp toward the goal
	logic [55:0]        step;
	logic signed [31:0] goal;
	logic [31:0]        mag_prop;
	logic [31:0]        mag_ramp;
	logic               use_ramp;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic               far;
	logic signed [31:0] ramped;
	logic signed [31:0] next;
	always_comb begin
		step     = prod_q[55:0];
		goal     = stop_q ? 32'sd0 : prop_q;
		mag_prop = prop_q[31] ? 32'(-prop_q) : prop_q;
		mag_ramp = ramp_q[31] ? 32'(-ramp_q) : ramp_q;
		use_ramp = stop_q || (mag_prop > mag_ramp)
			|| (prop_q < 0 && ramp_q > 0) || (prop_q > 0 && ramp_q < 0);
		diff     = $signed({goal[31], goal}) - $signed({ramp_q[31], ramp_q});
		diff_mag = diff[32] ? 33'(-diff) : diff;
		far      = {23'b0, diff_mag} > step;
		if (diff == 0)    ramped = ramp_q;
		else if (!far)    ramped = goal;
		else if (!diff[32]) ramped = ramp_q + $signed(step[31:0]);
		else              ramped = ramp_q - $signed(step[31:0]);
		next     = use_ramp ? ramped : prop_q;
	end

	// apply stage helpers
	logic               flip;
	logic signed [32:0] pos_err;
	logic [32:0]        err_mag;
	logic signed [32:0] vsum;
	logic signed [31:0] vout;
	always_comb begin
		flip    = (next_q < 0 && ramp_q > 0) || (next_q > 0 && ramp_q < 0);
		pos_err = $signed({meas_q[31], meas_q}) - $signed({target_q[31], target_q});
		err_mag = pos_err[32] ? 33'(-pos_err) : pos_err;
		if (next_q[31]) vsum = $signed({next_q[31], next_q}) - $signed({2'b00, min_q});
		else            vsum = $signed({next_q[31], next_q}) + $signed({2'b00, min_q});
		if (next_q == 0)              vout = '0;
		else if (vsum[32] != vsum[31]) vout = vsum[32] ? S32_MIN : S32_MAX;
		else                          vout = vsum[31:0];
	end

	// divider for the coast stop position
	logic [DIVIDEND_W-1:0] div_quot;
	logic                  div_done;
	logic                  div_start;
	assign div_start = (state_q == ST_DIV_START);

	pcr_div #(
		.DividendW(DIVIDEND_W),
		.DivisorW (DIVISOR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({ramp_q[31] ? 32'(-ramp_q) : ramp_q, 16'b0}),
		.divisor (gain_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	logic signed [49:0] quot_s;
	logic signed [49:0] pos_sum;
	logic signed [31:0] stop_pos;
	always_comb begin
		quot_s  = ramp_q[31] ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
		pos_sum = $signed({{18{meas_q[31]}}, meas_q}) + quot_s;
		if (gain_q == '0) begin
			if (ramp_q > 0)      stop_pos = S32_MAX;
			else if (ramp_q < 0) stop_pos = S32_MIN;
			else                 stop_pos = meas_q;
		end else if (pos_sum > 50'sh7fff_ffff) begin
			stop_pos = S32_MAX;
		end else if (pos_sum < -50'sh8000_0000) begin
			stop_pos = S32_MIN;
		end else begin
			stop_pos = pos_sum[31:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (accept) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!run_q || reached_q || rev_hold) state_d = ST_DIV_START;
				else                                 state_d = ST_MUL_ERR;
			end
			ST_MUL_ERR:   state_d = ST_MUL_DT;
			ST_MUL_DT:    state_d = ST_RAMP;
			ST_RAMP:      state_d = ST_APPLY;
			ST_APPLY:     state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV;
			ST_DIV:       if (div_done) state_d = ST_FIN;
			ST_FIN:       if (fin_go) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 24'd65536;
			limit_q   <= '0;
			min_q     <= '0;
			accel_q   <= '0;
			win_q     <= '0;
			settle_q  <= '0;
			revwait_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN:      gain_q    <= cfg_data[23:0];
				REG_COAST_LIM: limit_q   <= cfg_data[30:0];
				REG_MIN_SPEED: min_q     <= cfg_data[30:0];
				REG_ACCEL:     accel_q   <= cfg_data[23:0];
				REG_WINDOW:    win_q     <= cfg_data[30:0];
				REG_SETTLE:    settle_q  <= cfg_data;
				REG_REV_WAIT:  revwait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			target_q    <= '0;
			coast_q     <= '0;
			ramp_q      <= '0;
			outvel_q    <= '0;
			reached_q   <= 1'b1;
			win_entry_q <= '0;
			rev_time_q  <= '0;
			rev_pend_q  <= 1'b0;
			paused_q    <= 1'b0;
			stop_q      <= 1'b0;
			run_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_word.load_target) begin
							target_q  <= in_word.new_target;
							reached_q <= 1'b0;
						end
						if (in_word.load_coast) coast_q <= in_word.new_coast_speed;
						if (in_word.stop_request)     stop_q <= 1'b1;
						else if (in_word.load_target) stop_q <= 1'b0;
						paused_q    <= resume ? 1'b0 : paused_new;
						last_time_q <= in_word.time_us;
						run_q       <= !resume && !paused_new && !dt_full[31] && (dt_full != '0);
					end
				end
				ST_CHECK: begin
					if (run_q) begin
						if (reached_q) begin
							ramp_q   <= '0;
							outvel_q <= '0;
						end else if (!rev_hold) begin
							rev_pend_q <= 1'b0;
						end
					end
				end
				ST_APPLY: begin
					if (flip) begin
						rev_time_q <= now_q;
						rev_pend_q <= 1'b1;
						ramp_q     <= '0;
						outvel_q   <= '0;
					end else begin
						ramp_q   <= next_q;
						outvel_q <= vout;
						if (stop_q && next_q == 0) begin
							reached_q <= 1'b1;
						end else if (win_q != '0) begin
							if (err_mag >= {2'b00, win_q}) win_entry_q <= now_q;
							else if ((now_q - win_entry_q) > settle_q) reached_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= in_word.time_us;
			meas_q <= in_word.measured_position;
			dt_q   <= dt_full[30:0];
		end
		if (state_q == ST_MUL_ERR || state_q == ST_MUL_DT) prod_q <= mul_p;
		if (state_q == ST_MUL_DT) prop_q <= prop_clamp;
		if (state_q == ST_RAMP)   next_q <= next;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         out_valid_q <= 1'b0;
		else if (fin_go)     out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.velocity_command    <= outvel_q;
			out_q.at_target           <= reached_q;
			out_q.is_paused           <= paused_q;
			out_q.coast_stop_position <= stop_pos;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// a new word is never taken while one is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("word accepted while busy");

	// a direction reversal always forces zero output
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rev_pend_q) |-> outvel_q == 32'sd0)
		else $error("reversal without zero output");

	// divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside wait state");

endmodule
